### hdl/assert_macros.svh
// Assertion helper macros for the AES block cipher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, prop)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hdl/aes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES package
// Types, constants and byte-level functions shared by the AES modules.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned RkwDepth = 60;
  localparam int unsigned RkwAw    = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegKeySize = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey0    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey1    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey2    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKey3    = 3'd4;

  localparam logic [1:0] KeyInvalid = 2'd3;
  localparam logic       OpDecrypt  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    logic        status;
  } aes_out_t;

  // controller to datapath
  typedef struct packed {
    logic       load;      // load state from input
    logic       ks_init;   // clear expansion counter
    logic       ks_step;   // advance key expansion by one step
    logic       rk_rd;     // issue round key read
    logic [1:0] rk_col;    // column of the round key being read
    logic [3:0] rk_round;  // round being read
    logic       rnd;       // run one round
    logic       last;      // final round (no mix)
    logic       first_ark; // add key only, no round functions
  } aes_ctrl_t;

  typedef struct packed {
    logic ks_done;
  } aes_stat_t;

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[a];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // forward mix of one column, byte 0 in the top bits
  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    mix_col = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
               a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
               a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
               xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // inverse mix: precondition with {5,0,4,0} then forward mix
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    u = xtime(xtime(a0 ^ a2));
    v = xtime(xtime(a1 ^ a3));
    inv_mix_col = mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

endpackage

### hdl/aes_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES controller
// Sequences key expansion, round key reads and rounds for one item.
// ----------------------------------------------------------------------------
module aes_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                op_i,
  input  logic [1:0]          key_size_i,
  input  logic                cfg_we_i,
  input  aes_pkg::aes_stat_t  stat_i,
  output aes_pkg::aes_ctrl_t  ctrl_o,
  output logic                busy,
  output logic                done_o,
  output logic                bad_key_o
);
  import aes_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StExpand = 3'd1;
  localparam logic [2:0] StRead   = 3'd2;
  localparam logic [2:0] StRound  = 3'd3;
  localparam logic [2:0] StDone   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       expanded_q, expanded_d;
  logic       op_q, op_d;
  logic [3:0] nr_q, nr_d;
  logic [3:0] step_q, step_d;  // number of rounds done
  logic [1:0] col_q, col_d;
  logic       bad_q, bad_d;
  logic [3:0] nr_new;

  assign nr_new = 4'd10 + {1'b0, key_size_i, 1'b0};

  // round whose key is being fetched
  logic [3:0] rd_round;
  always_comb begin
    if (op_q == OpDecrypt) rd_round = nr_q - step_q;
    else rd_round = step_q;
  end

  // next state
  always_comb begin
    state_d    = state_q;
    expanded_d = expanded_q;
    op_d       = op_q;
    nr_d       = nr_q;
    step_d     = step_q;
    col_d      = col_q;
    bad_d      = bad_q;
    ctrl_o     = '0;
    ctrl_o.rk_col   = col_q;
    ctrl_o.rk_round = rd_round;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          op_d   = op_i;
          nr_d   = nr_new;
          step_d = '0;
          col_d  = '0;
          ctrl_o.load = 1'b1;
          if (key_size_i == KeyInvalid) begin
            bad_d   = 1'b1;
            state_d = StDone;
          end else begin
            bad_d = 1'b0;
            if (expanded_q) begin
              state_d = StRead;
            end else begin
              ctrl_o.ks_init = 1'b1;
              state_d = StExpand;
            end
          end
        end
      end
      StExpand: begin
        ctrl_o.ks_step = 1'b1;
        if (stat_i.ks_done) begin
          ctrl_o.ks_step = 1'b0;
          expanded_d = 1'b1;
          state_d    = StRead;
        end
      end
      StRead: begin
        // four words, one per cycle, into the key register
        ctrl_o.rk_rd = 1'b1;
        col_d = col_q + 2'd1;
        if (col_q == 2'd3) state_d = StRound;
      end
      StRound: begin
        // last key word lands this cycle; apply the round next edge
        ctrl_o.rnd       = 1'b1;
        ctrl_o.first_ark = (step_q == 4'd0);
        ctrl_o.last      = (step_q == nr_q);
        step_d = step_q + 4'd1;
        if (step_q == nr_q) state_d = StDone;
        else state_d = StRead;
      end
      StDone: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    if (cfg_we_i) expanded_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      expanded_q <= 1'b0;
      op_q       <= 1'b0;
      nr_q       <= '0;
      step_q     <= '0;
      col_q      <= '0;
      bad_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      expanded_q <= expanded_d;
      op_q       <= op_d;
      nr_q       <= nr_d;
      step_q     <= step_d;
      col_q      <= col_d;
      bad_q      <= bad_d;
    end
  end

  assign busy      = (state_q != StIdle);
  assign done_o    = (state_q == StDone);
  assign bad_key_o = bad_q;

  `ASSERT_NEXT(a_done_one, state_q == StDone, state_q == StIdle)
  `ASSERT_NEXT(a_cfg_clears, cfg_we_i, !expanded_q)
  `ASSERT_IMPL(a_round_range, !(state_q == StRound) || step_q <= nr_q)
endmodule

### hdl/aes_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES datapath
// Key schedule store with word-serial expansion and the round state.
// ----------------------------------------------------------------------------
module aes_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aes_pkg::aes_ctrl_t  ctrl_i,
  input  aes_pkg::aes_in_t    item_i,
  input  logic [1:0]          key_size_i,
  input  logic [255:0]        key_i,
  input  logic                dec_i,
  output aes_pkg::aes_stat_t  stat_o,
  output logic [127:0]        state_o
);
  import aes_pkg::*;
  `include "assert_macros.svh"

  logic [31:0]     rkw_mem [RkwDepth];
  logic [31:0]     rd_data_q;
  logic [RkwAw-1:0] wr_idx_q, wr_idx_d;
  logic [31:0]     w1_q, w1_d;   // w[i-1]
  logic [7:0]      rcon_q, rcon_d;
  logic [2:0]      pos_q, pos_d; // i mod nk
  logic [31:0]     back_q;       // w[i-nk] read from store
  logic            phase_q, phase_d;
  logic [3:0]      nk;
  logic [RkwAw-1:0] total;
  logic [RkwAw-1:0] rd_addr;
  logic            we;
  logic [RkwAw-1:0] wa;
  logic [31:0]     wd;
  logic [31:0]     t;
  logic [127:0]    rk_q;
  logic [127:0]    st_q, st_d;
  logic            dec_q;

  assign nk    = 4'd4 + {1'b0, key_size_i, 1'b0};
  assign total = 6'd44 + {1'b0, key_size_i, 3'b000} + {2'b0, key_size_i, 2'b00} - 6'd4 * {4'b0, key_size_i};

  // schedule transform on w[i-1]
  always_comb begin
    t = w1_q;
    if (pos_q == 3'd0) t = sub_word({w1_q[23:0], w1_q[31:24]}) ^ {rcon_q, 24'h0};
    else if (nk == 4'd8 && pos_q == 3'd4) t = sub_word(w1_q);
  end

  // expansion: key words copied, then each generated word reads w[i-nk] from the store and then writes
  always_comb begin
    wr_idx_d = wr_idx_q;
    w1_d     = w1_q;
    rcon_d   = rcon_q;
    pos_d    = pos_q;
    phase_d  = phase_q;
    we       = 1'b0;
    wa       = wr_idx_q;
    wd       = '0;
    rd_addr  = {ctrl_i.rk_round, 2'b00} + {4'b0, ctrl_i.rk_col};
    if (ctrl_i.ks_init) begin
      wr_idx_d = '0;
      rcon_d   = 8'h01;
      pos_d    = '0;
      phase_d  = 1'b0;
    end else if (ctrl_i.ks_step) begin
      if (wr_idx_q < RkwAw'(nk)) begin
        we   = 1'b1;
        wd   = key_i[255 - 32*wr_idx_q[2:0] -: 32];
        w1_d = wd;
        wr_idx_d = wr_idx_q + RkwAw'(1);
      end else if (!phase_q) begin
        rd_addr = wr_idx_q - RkwAw'(nk);
        phase_d = 1'b1;
      end else begin
        we   = 1'b1;
        wd   = back_q ^ t;
        w1_d = wd;
        phase_d  = 1'b0;
        wr_idx_d = wr_idx_q + RkwAw'(1);
        if (pos_q == 3'(nk - 4'd1)) begin
          pos_d = '0;
        end else begin
          pos_d = pos_q + 3'd1;
        end
        if (pos_q == 3'd0) rcon_d = xtime(rcon_q);
      end
    end
  end
  assign back_q = rd_data_q;
  assign stat_o.ks_done = (wr_idx_q == total) && !ctrl_i.ks_init;

  always_ff @(posedge clk_i) begin
    if (we) rkw_mem[wa] <= wd;
    rd_data_q <= rkw_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      phase_q  <= 1'b0;
      pos_q    <= '0;
      rcon_q   <= 8'h01;
    end else begin
      wr_idx_q <= wr_idx_d;
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      rcon_q   <= rcon_d;
    end
  end

  // key word from the previous read shifts into the round key register
  logic rd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_q <= 1'b0;
    else rd_q <= ctrl_i.rk_rd;
  end

  always_ff @(posedge clk_i) begin
    w1_q <= w1_d;
    if (rd_q) rk_q <= {rk_q[95:0], rd_data_q};
  end

  // one round; rk joins rk_q with the fourth word still on the read port
  logic [127:0] rk;
  logic [127:0] sb, sr, mx, x;
  assign rk = {rk_q[95:0], rd_data_q};
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[127-8*i -: 8] = dec_q ? inv_sbox(st_q[127-8*i -: 8]) : sbox(st_q[127-8*i -: 8]);
    end
    sr = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec_q) sr[127-8*(4*((c+r)%4)+r) -: 8] = sb[127-8*(4*c+r) -: 8];
        else sr[127-8*(4*c+r) -: 8] = sb[127-8*(4*((c+r)%4)+r) -: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      mx[127-32*c -: 32] = mix_col(sr[127-32*c -: 32]);
    end
    x    = sr ^ rk;
    st_d = st_q;
    if (ctrl_i.load) begin
      st_d = {item_i.block_hi, item_i.block_lo};
    end else if (ctrl_i.rnd) begin
      if (ctrl_i.first_ark) begin
        st_d = st_q ^ rk;
      end else if (ctrl_i.last) begin
        st_d = sr ^ rk;
      end else if (dec_q) begin
        for (int c = 0; c < 4; c++) st_d[127-32*c -: 32] = inv_mix_col(x[127-32*c -: 32]);
      end else begin
        st_d = mx ^ rk;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (ctrl_i.load) dec_q <= dec_i;
  end
  assign state_o = st_q;

  `ASSERT_IMPL(a_no_write_beyond, !we || wa < RkwAw'(RkwDepth))
  `ASSERT_IMPL(a_phase_copy, !(phase_q && wr_idx_q < RkwAw'(nk)))
  `ASSERT_NEXT(a_init_clear, ctrl_i.ks_init, wr_idx_q == '0)
endmodule

### hdl/aes_block_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES block cipher top level
// Encrypts or decrypts one 128-bit item with a 128/192/256-bit key.
// ----------------------------------------------------------------------------
// One item at a time. For each of the Nr+1 key additions an item reads four
// key words from the schedule store's single read port and then applies the
// round. The first item after reset or any write to the key size or key
// registers also expands the key schedule first: key words are copied, then
// each further word is generated from a store read. An invalid key size
// returns status 1 and a zero result in the cycle after the item is accepted.
// The result is shown for one cycle with done_o and cannot be held off by the
// receiver.
module aes_block_cipher (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  aes_pkg::aes_in_t                 item_i,
  output logic                             done_o,
  output aes_pkg::aes_out_t                result_o,
  input  logic                             cfg_we_i,
  input  logic [aes_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [aes_pkg::CfgDataW-1:0]     cfg_data_i
);
  import aes_pkg::*;

  logic [1:0]   key_size_q;
  logic [255:0] key_q;
  aes_ctrl_t    ctrl;
  aes_stat_t    stat;
  logic         done, bad;
  logic [127:0] st;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_size_q <= KeyInvalid;
      key_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegKeySize: key_size_q <= cfg_data_i[1:0];
        RegKey0:    key_q[255:192] <= cfg_data_i;
        RegKey1:    key_q[191:128] <= cfg_data_i;
        RegKey2:    key_q[127:64]  <= cfg_data_i;
        RegKey3:    key_q[63:0]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic cfg_hit;
  assign cfg_hit = cfg_we_i && (cfg_idx_i <= RegKey3);

  aes_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .op_i(item_i.operation), .key_size_i(key_size_q),
    .cfg_we_i(cfg_hit), .stat_i(stat), .ctrl_o(ctrl), .busy, .done_o(done),
    .bad_key_o(bad)
  );

  aes_dpath u_dpath (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .item_i, .key_size_i(key_size_q),
    .key_i(key_q), .dec_i(item_i.operation), .stat_o(stat), .state_o(st)
  );

  assign done_o             = done;
  assign result_o.result_hi = bad ? 64'h0 : st[127:64];
  assign result_o.result_lo = bad ? 64'h0 : st[63:0];
  assign result_o.status    = bad;
endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES block cipher testbench
// Drives blocks through encrypt and decrypt under several key sizes and keys,
// predicts every result with an independent AES model and checks each
// result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

// Holds predicted results in order and compares them with what comes out
class aes_scoreboard;
  aes_pkg::aes_out_t pending[$];
  int errors = 0;

  function void note_item(aes_pkg::aes_out_t predicted);
    pending.push_back(predicted);
  endfunction

  function void check_result(aes_pkg::aes_out_t got);
    aes_pkg::aes_out_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.result_hi !== want.result_hi) begin
      $display("%0t: result_hi expected %h actual %h", $time, want.result_hi, got.result_hi);
      errors++;
    end
    if (got.result_lo !== want.result_lo) begin
      $display("%0t: result_lo expected %h actual %h", $time, want.result_lo, got.result_lo);
      errors++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status expected %h actual %h", $time, want.status, got.status);
      errors++;
    end
  endfunction
endclass

module tb;
  import aes_pkg::*;

  localparam int unsigned TargetItems = 1750;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  aes_in_t           item_i = '0;
  logic              done_o;
  aes_out_t          result_o;
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  aes_scoreboard sb = new();

  // predictor state
  logic [7:0]  fwd_sbox [256];
  logic [7:0]  rev_sbox [256];
  logic [31:0] sched [60];
  logic [1:0]  cur_ksize;
  logic [63:0] cur_key [4];
  bit          sched_valid;
  logic [7:0]  st [16];

  int unsigned sent = 0;
  int unsigned burst_left = 0;

  aes_block_cipher i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  function automatic logic [7:0] gf_dbl(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_dbl(a);
    end
    return acc;
  endfunction

  // S-boxes from the field inverse and the affine map
  function void build_sboxes();
    logic [7:0] y, s;
    for (int x = 0; x < 256; x++) begin
      y = 8'h00;
      for (int k = 1; k < 256; k++)
        if (x != 0 && gf_mul(x[7:0], k[7:0]) == 8'h01) y = k[7:0];
      s = y ^ {y[6:0], y[7]} ^ {y[5:0], y[7:6]} ^ {y[4:0], y[7:5]} ^ {y[3:0], y[7:4]} ^ 8'h63;
      fwd_sbox[x] = s;
      rev_sbox[s] = x[7:0];
    end
  endfunction

  function void expand_schedule(int nk, int total);
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      sched[i] = i[0] ? cur_key[i >> 1][31:0] : cur_key[i >> 1][63:32];
    for (int i = nk; i < total; i++) begin
      t = sched[i-1];
      if (i % nk == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_sbox[t[31:24]], fwd_sbox[t[23:16]], fwd_sbox[t[15:8]], fwd_sbox[t[7:0]]};
        t ^= {rc, 24'h0};
        rc = gf_dbl(rc);
      end else if (nk == 8 && i % nk == 4) begin
        t = {fwd_sbox[t[31:24]], fwd_sbox[t[23:16]], fwd_sbox[t[15:8]], fwd_sbox[t[7:0]]};
      end
      sched[i] = sched[i-nk] ^ t;
    end
    sched_valid = 1'b1;
  endfunction

  function void add_key(int round);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        st[4*c+r] ^= sched[round*4+c][31-8*r -: 8];
  endfunction

  function void sub_state(bit inv);
    for (int i = 0; i < 16; i++) st[i] = inv ? rev_sbox[st[i]] : fwd_sbox[st[i]];
  endfunction

  function void shift_state(bit inv);
    logic [7:0] t [16];
    t = st;
    for (int c = 0; c < 4; c++)
      for (int r = 1; r < 4; r++)
        if (inv) st[4*((c+r)%4)+r] = t[4*c+r];
        else     st[4*c+r] = t[4*((c+r)%4)+r];
  endfunction

  function void mix_state(bit inv);
    logic [7:0] col [4];
    logic [7:0] m [4];
    logic [7:0] v;
    if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else     m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) col[k] = st[4*c+k];
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v ^= gf_mul(col[k], m[(k+4-r)%4]);
        st[4*c+r] = v;
      end
    end
  endfunction

  function aes_out_t predict_block(aes_in_t it);
    aes_out_t o;
    int nk, nr;
    o = '0;
    if (cur_ksize == KeyInvalid) begin
      o.status = 1'b1;
      return o;
    end
    nk = 4 + 2 * cur_ksize;
    nr = nk + 6;
    if (!sched_valid) expand_schedule(nk, 4 * (nr + 1));
    for (int i = 0; i < 8; i++) begin
      st[i]   = it.block_hi[63-8*i -: 8];
      st[8+i] = it.block_lo[63-8*i -: 8];
    end
    if (it.operation != OpDecrypt) begin
      add_key(0);
      for (int rd = 1; rd < nr; rd++) begin
        sub_state(0); shift_state(0); mix_state(0); add_key(rd);
      end
      sub_state(0); shift_state(0); add_key(nr);
    end else begin
      add_key(nr);
      for (int rd = nr - 1; rd >= 1; rd--) begin
        shift_state(1); sub_state(1); add_key(rd); mix_state(1);
      end
      shift_state(1); sub_state(1); add_key(0);
    end
    for (int i = 0; i < 8; i++) begin
      o.result_hi[63-8*i -: 8] = st[i];
      o.result_lo[63-8*i -: 8] = st[8+i];
    end
    return o;
  endfunction

  // ---------------------------------------------------------------- drivers
  // one item; the sender runs in bursts with random gaps between them
  task send_block(logic op, logic [63:0] hi, logic [63:0] lo);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    start = 1'b1;
    item_i.operation = op;
    item_i.block_hi = hi;
    item_i.block_lo = lo;
    do @(posedge clk_i); while (busy);
    sb.note_item(predict_block(item_i));
    sent++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // let every outstanding result come back and the block go idle
  task drain();
    start = 1'b0;
    while (sb.pending.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == RegKeySize) cur_ksize = data[1:0];
    else if (idx <= RegKey3) cur_key[idx - RegKey0] = data;
    if (idx <= RegKey3) sched_valid = 1'b0;
  endtask

  task write_key(logic [1:0] ks, logic [63:0] k0, logic [63:0] k1,
                 logic [63:0] k2, logic [63:0] k3);
    drain();
    write_reg(RegKey0, k0);
    write_reg(RegKey1, k1);
    write_reg(RegKey2, k2);
    write_reg(RegKey3, k3);
    write_reg(RegKeySize, {$urandom, $urandom_range(0, 1) ? 30'h0 : 30'h3fff_ffff, ks});
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // result monitor
  always @(posedge clk_i)
    if (rst_ni && done_o) sb.check_result(result_o);

  // ---------------------------------------------------------------- stimulus
  initial begin
    int n;
    logic [1:0] ks;
    build_sboxes();
    cur_ksize = KeyInvalid;
    cur_key = '{default: '0};
    sched_valid = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // no valid key out of reset
    send_block(0, '1, '1);
    send_block(1, '0, '0);

    // FIPS-197 128-bit example, forward and back
    write_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
    send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(0, '0, '0);
    send_block(1, '1, '1);

    // 192-bit key all ones, 256-bit key all zeros and all ones
    write_key(2'd1, '1, '1, '1, '0);
    send_block(0, '0, '1);
    send_block(1, '1, '0);
    send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    write_key(2'd2, '0, '0, '0, '0);
    send_block(0, '0, '0);
    send_block(1, '0, '0);
    write_key(2'd2, '1, '1, '1, '1);
    send_block(0, '1, '1);
    send_block(1, '1, '1);
    // FIPS-197 256-bit example
    write_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
              64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);

    // invalid size again; the key stays invalid for the items below
    write_key(KeyInvalid, '1, '1, '1, '1);
    send_block(0, '1, '0);
    // writes past the register list change nothing
    drain();
    write_reg(3'd5, '1);
    write_reg(3'd7, '0);
    send_block(1, '0, '1);

    // random phases
    while (sent < TargetItems) begin
      ks = ($urandom_range(0, 9) == 9) ? KeyInvalid : 2'($urandom_range(0, 2));
      write_key(ks, rand_word(), rand_word(), rand_word(), rand_word());
      if ($urandom_range(0, 3) == 0) write_reg(3'($urandom_range(5, 7)), rand_word());
      if ($urandom_range(0, 3) == 0)
        write_reg(3'($urandom_range(RegKey0, RegKey3)), rand_word());
      n = $urandom_range(20, 80);
      for (int i = 0; i < n; i++) begin
        // hold off once in a while until everything has come back
        if (i == 10 && $urandom_range(0, 2) == 0) drain();
        send_block($urandom_range(0, 1), rand_word(), rand_word());
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
